// ===== sv/antialiased_point_splat_compositor_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the point splat compositor
// Shared shorthand for clocked assertions, checked out of reset.
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_POINT_SPLAT_COMPOSITOR_DEFINES_SVH
`define ANTIALIASED_POINT_SPLAT_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, ignored while rst is high.
`define APSC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while rst is high.
`define APSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/apsc_pkg.sv =====
// ----------------------------------------------------------------------------
// apsc_pkg
// Operation codes, register indexes, constants and the command type that
// travels from the front end through the queue to the plane engine.
// ----------------------------------------------------------------------------
package apsc_pkg;

  localparam logic [1:0] OP_SPLAT = 2'd0;
  localparam logic [1:0] OP_MERGE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic REG_PEN  = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  localparam logic [3:0]  PEN_RESET  = 4'd11;
  localparam logic [8:0]  SIZE_RESET = 9'd256;
  localparam logic [3:0]  COV_MAX    = 4'd15;
  localparam logic [8:0]  FRAC_ONE   = 9'd256;
  localparam logic [20:0] ROUND_HALF = 21'd32768;

  localparam int QDEPTH = 2;
  localparam int QPW    = 1;

  typedef struct packed {
    logic [1:0]         op;
    logic               halve;
    logic signed [11:0] ix;
    logic signed [11:0] iy;
    logic [7:0]         tx;
    logic [7:0]         ty;
    logic [7:0]         rd_x;
    logic [7:0]         rd_y;
    logic               rd_ok;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/apsc_fifo.sv =====
// ----------------------------------------------------------------------------
// apsc_fifo
// Short command queue between the front end and the plane engine.
// ----------------------------------------------------------------------------
module apsc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  apsc_pkg::cmd_t  push_data,
  input  logic            pop,
  output apsc_pkg::cmd_t  head,
  output apsc_pkg::q_stat_t stat
);

  apsc_pkg::cmd_t entries [apsc_pkg::QDEPTH];
  logic [apsc_pkg::QPW-1:0] wr_ptr;
  logic [apsc_pkg::QPW-1:0] rd_ptr;
  logic [apsc_pkg::QPW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == (apsc_pkg::QPW+1)'(apsc_pkg::QDEPTH));
  assign stat.empty = (count == '0);

endmodule

// ===== sv/apsc_front.sv =====
// ----------------------------------------------------------------------------
// apsc_front
// Takes input transactions, decodes them into commands (pixel and fraction
// split for splats, range check for reads) and pushes them into the queue.
// ----------------------------------------------------------------------------
module apsc_front #(
  parameter int PLANE_MAX = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                init_busy,
  input  logic [$clog2(PLANE_MAX+1)-1:0] active_size,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic signed [19:0]  point_x,
  input  logic signed [19:0]  point_y,
  input  logic                halve_scratch,
  input  logic [7:0]          read_x,
  input  logic [7:0]          read_y,
  input  apsc_pkg::q_stat_t   q_stat,
  output logic                q_push,
  output apsc_pkg::cmd_t      q_data
);

  localparam int ASW = $clog2(PLANE_MAX + 1);
  localparam int RW  = (ASW > 8) ? ASW : 8;

  logic           cmd_valid;
  apsc_pkg::cmd_t cmd;
  apsc_pkg::cmd_t cmd_next;
  logic           accept;

  assign q_push   = cmd_valid && !q_stat.full;
  assign in_stall = init_busy || (cmd_valid && q_stat.full);
  assign accept   = in_valid && !in_stall;
  assign q_data   = cmd;

  always_comb begin
    cmd_next.op    = operation;
    cmd_next.halve = halve_scratch;
    cmd_next.ix    = point_x[19:8];
    cmd_next.iy    = point_y[19:8];
    cmd_next.tx    = point_x[7:0];
    cmd_next.ty    = point_y[7:0];
    cmd_next.rd_x  = read_x;
    cmd_next.rd_y  = read_y;
    cmd_next.rd_ok = (RW'(read_x) < RW'(active_size)) &&
                     (RW'(read_y) < RW'(active_size));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (q_push) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== sv/apsc_back.sv =====
// ----------------------------------------------------------------------------
// apsc_back
// Plane engine: owns the scratch and result memories, runs splat corners
// through a two-stage read-modify-write pipe, sweeps the planes for merge,
// clear and the post-reset clearing pass, and holds the output register.
// ----------------------------------------------------------------------------
`include "antialiased_point_splat_compositor_defines.svh"

module apsc_back #(
  parameter int PLANE_MAX = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [3:0]         ink_level,
  input  logic [$clog2(PLANE_MAX+1)-1:0] active_size,
  input  apsc_pkg::cmd_t     q_head,
  input  apsc_pkg::q_stat_t  q_stat,
  output logic               pop,
  output logic               init_busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         coverage
);

  localparam int XW    = $clog2(PLANE_MAX);
  localparam int ASW   = $clog2(PLANE_MAX + 1);
  localparam int DEPTH = PLANE_MAX * PLANE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMPW  = (ASW > 13) ? ASW : 13;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SPLAT = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [2:0] K_LAST = 3'd5;

  logic [3:0] scratch_mem [DEPTH];
  logic [3:0] result_mem  [DEPTH];

  logic [2:0]      state;
  logic [2:0]      state_next;
  apsc_pkg::cmd_t  cur;
  logic [2:0]      k;
  logic [AW-1:0]   sweep_addr;
  logic [XW-1:0]   sx;
  logic [XW-1:0]   sy;
  logic            sweeping;
  logic            sweep_last;
  logic            out_load;

  // splat pipe
  logic [8:0]         ux;
  logic [8:0]         uy;
  logic [8:0]         fa;
  logic [8:0]         fb;
  logic signed [12:0] cx0;
  logic signed [12:0] cy0;
  logic signed [12:0] sel_cx;
  logic signed [12:0] sel_cy;
  logic [17:0]        corner_prod;
  logic               a_valid;
  logic [16:0]        a_w;
  logic signed [12:0] a_cx;
  logic signed [12:0] a_cy;
  logic [20:0]        pen_prod;
  logic [20:0]        pen_round;
  logic               a_in;
  logic [AW-1:0]      b_addr_next;
  logic               b_valid;
  logic               b_ok;
  logic [3:0]         b_v;
  logic [AW-1:0]      b_addr;

  // merge stage
  logic          m_valid;
  logic          m_act;
  logic [AW-1:0] m_addr;
  logic [4:0]    m_s;
  logic [4:0]    m_sum;

  // memory ports
  logic [AW-1:0] sc_raddr;
  logic [3:0]    sc_rd;
  logic          sc_we;
  logic [AW-1:0] sc_waddr;
  logic [3:0]    sc_wdata;
  logic [AW-1:0] res_raddr;
  logic [3:0]    res_rd;
  logic          res_we;
  logic [AW-1:0] res_waddr;
  logic [3:0]    res_wdata;
  logic [AW-1:0] rd_addr;

  assign init_busy  = (state == S_INIT);
  assign pop        = (state == S_IDLE) && !q_stat.empty;
  assign sweeping   = (state == S_INIT) || (state == S_MERGE) || (state == S_CLEAR);
  assign sweep_last = (sweep_addr == AW'(DEPTH - 1));
  assign out_load   = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (pop) begin
          case (q_head.op)
            apsc_pkg::OP_SPLAT: state_next = S_SPLAT;
            apsc_pkg::OP_MERGE: state_next = S_MERGE;
            apsc_pkg::OP_CLEAR: state_next = S_CLEAR;
            default:            state_next = S_READ;
          endcase
        end
      end
      S_SPLAT: begin
        if (k == K_LAST) state_next = S_DONE;
      end
      S_MERGE, S_CLEAR: begin
        if (sweep_last) state_next = S_DONE;
      end
      S_READ: state_next = S_DONE;
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      k          <= '0;
      sweep_addr <= '0;
      sx         <= '0;
      sy         <= '0;
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      m_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      a_valid <= (state == S_SPLAT) && !k[2];
      b_valid <= a_valid;
      m_valid <= (state == S_MERGE);
      if (state == S_SPLAT) begin
        k <= k + 1'b1;
      end else begin
        k <= '0;
      end
      // sweep counters always return to zero at the end of a pass
      if (sweeping) begin
        if (sweep_last) begin
          sweep_addr <= '0;
          sx         <= '0;
          sy         <= '0;
        end else begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sx == XW'(PLANE_MAX - 1)) begin
            sx <= '0;
            sy <= sy + 1'b1;
          end else begin
            sx <= sx + 1'b1;
          end
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (out_load) begin
      coverage <= (cur.op == apsc_pkg::OP_READ && cur.rd_ok) ? res_rd : 4'd0;
    end
  end

  // corner select: k[0] picks x+1, k[1] picks y+1
  always_comb begin
    ux  = apsc_pkg::FRAC_ONE - {1'b0, cur.tx};
    uy  = apsc_pkg::FRAC_ONE - {1'b0, cur.ty};
    cx0 = {cur.ix[11], cur.ix};
    cy0 = {cur.iy[11], cur.iy};
    fa     = k[0] ? {1'b0, cur.tx} : ux;
    sel_cx = k[0] ? cx0 + 13'sd1 : cx0;
    fb     = k[1] ? {1'b0, cur.ty} : uy;
    sel_cy = k[1] ? cy0 + 13'sd1 : cy0;
    corner_prod = 18'(fa) * 18'(fb);
  end

  always_ff @(posedge clk) begin
    a_w  <= corner_prod[16:0];
    a_cx <= sel_cx;
    a_cy <= sel_cy;
  end

  always_comb begin
    pen_prod  = 21'(a_w) * 21'(ink_level);
    pen_round = pen_prod + apsc_pkg::ROUND_HALF;
    a_in = !a_cx[12] && !a_cy[12] &&
           (CMPW'(a_cx[11:0]) < CMPW'(active_size)) &&
           (CMPW'(a_cy[11:0]) < CMPW'(active_size));
    b_addr_next = AW'(a_cy[11:0]) * AW'(PLANE_MAX) + AW'(a_cx[11:0]);
  end

  always_ff @(posedge clk) begin
    b_v    <= pen_round[19:16];
    b_ok   <= a_in && (pen_round[19:16] != 4'd0);
    b_addr <= b_addr_next;
  end

  // merge: read both planes at sweep_addr, write back in the next cycle
  always_ff @(posedge clk) begin
    m_addr <= sweep_addr;
    m_act  <= (ASW'(sx) < active_size) && (ASW'(sy) < active_size);
  end

  always_comb begin
    m_s   = cur.halve ? ({1'b0, sc_rd} + 5'd1) >> 1 : {1'b0, sc_rd};
    m_sum = {1'b0, res_rd} + m_s;
  end

  assign rd_addr   = AW'(cur.rd_y) * AW'(PLANE_MAX) + AW'(cur.rd_x);
  assign sc_raddr  = (state == S_SPLAT) ? b_addr_next : sweep_addr;
  assign res_raddr = (state == S_READ || state == S_DONE) ? rd_addr : sweep_addr;

  always_comb begin
    sc_we    = 1'b0;
    sc_waddr = sweep_addr;
    sc_wdata = 4'd0;
    res_we    = 1'b0;
    res_waddr = sweep_addr;
    res_wdata = 4'd0;
    if (state == S_INIT || state == S_CLEAR) begin
      sc_we  = 1'b1;
      res_we = 1'b1;
    end else if (m_valid) begin
      sc_we     = 1'b1;
      sc_waddr  = m_addr;
      res_we    = m_act;
      res_waddr = m_addr;
      res_wdata = m_sum[4] ? apsc_pkg::COV_MAX : m_sum[3:0];
    end else if (b_valid && b_ok && (b_v > sc_rd)) begin
      sc_we    = 1'b1;
      sc_waddr = b_addr;
      sc_wdata = b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      scratch_mem[sc_waddr] <= sc_wdata;
    end
    sc_rd <= scratch_mem[sc_raddr];
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      result_mem[res_waddr] <= res_wdata;
    end
    res_rd <= result_mem[res_raddr];
  end

  `APSC_ASSERT(a_init_no_pop, state == S_INIT, !pop, "command taken during clearing pass")
  `APSC_ASSERT(a_splat_pipe, a_valid || b_valid, state == S_SPLAT, "splat pipe active outside splat")
  `APSC_ASSERT(a_merge_stage, m_valid, $past(state == S_MERGE), "merge write without merge read")
  `APSC_ASSERT_NEXT(a_pop_starts, pop, state != S_IDLE, "popped command did not start")

endmodule

// ===== sv/antialiased_point_splat_compositor.sv =====
// ----------------------------------------------------------------------------
// antialiased_point_splat_compositor
// Two PLANE_MAX x PLANE_MAX planes of 4-bit coverage with bilinear point
// splats into scratch, merge of scratch into result, clear and pixel read.
// ----------------------------------------------------------------------------
// Every transaction returns one coverage value (the pixel on an in-range
// read, else 0). A splat sends its four corners one per cycle through a
// multiply / round stage and a scratch read-modify-write. A read returns
// the pixel through the registered memory read. Merge and clear walk every
// memory entry once. After reset a clearing pass zeroes both planes;
// in_stall stays high until it ends, while register writes are taken as
// usual. A two-entry command queue lets the input side run ahead of the
// plane engine by up to three transactions.
// ----------------------------------------------------------------------------
module antialiased_point_splat_compositor #(
  parameter int PLANE_MAX = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic signed [19:0] point_x,
  input  logic signed [19:0] point_y,
  input  logic               halve_scratch,
  input  logic [7:0]         read_x,
  input  logic [7:0]         read_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         coverage,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int ASW = $clog2(PLANE_MAX + 1);
  localparam int SW  = (ASW > 9) ? ASW : 9;

  logic [3:0]     ink_level;
  logic [8:0]     plane_size;
  logic [ASW-1:0] active_size;
  logic           cfg_we;
  logic           init_busy;
  logic           q_push;
  logic           q_pop;
  apsc_pkg::cmd_t q_data;
  apsc_pkg::cmd_t q_head;
  apsc_pkg::q_stat_t q_stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ink_level  <= apsc_pkg::PEN_RESET;
      plane_size <= apsc_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        apsc_pkg::REG_PEN:  ink_level <= pwdata[3:0];
        apsc_pkg::REG_SIZE: plane_size <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      apsc_pkg::REG_PEN:  prdata = {28'd0, ink_level};
      apsc_pkg::REG_SIZE: prdata = {23'd0, plane_size};
      default:            prdata = 32'd0;
    endcase
  end

  assign active_size = (SW'(plane_size) > SW'(PLANE_MAX)) ? ASW'(PLANE_MAX)
                                                          : ASW'(plane_size);

  apsc_front #(
    .PLANE_MAX(PLANE_MAX)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .init_busy    (init_busy),
    .active_size  (active_size),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .point_x      (point_x),
    .point_y      (point_y),
    .halve_scratch(halve_scratch),
    .read_x       (read_x),
    .read_y       (read_y),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  apsc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  apsc_back #(
    .PLANE_MAX(PLANE_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .ink_level  (ink_level),
    .active_size(active_size),
    .q_head     (q_head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .coverage   (coverage)
  );

endmodule
